### rtl/pd_source_profile_selector_macros.svh
// ----------------------------------------------------------------------------
// pd_source_profile_selector_macros.svh
// Assertion shorthands for the profile selector checker.
// ----------------------------------------------------------------------------
`ifndef PD_SOURCE_PROFILE_SELECTOR_MACROS_SVH
`define PD_SOURCE_PROFILE_SELECTOR_MACROS_SVH

// same-cycle implication, off while in reset
`define PDSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define PDSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define PDSS_ASSERT_NXT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pdss_pkg.sv
// ----------------------------------------------------------------------------
// pdss_pkg
// Types and constants shared by the source profile selector.
// ----------------------------------------------------------------------------
package pdss_pkg;

    localparam int PDO_W      = 32;
    localparam int UNITS_W    = 10;
    localparam int CUR_W      = 14;
    localparam int VOLT_W     = 16;
    localparam int PWR_W      = 19;
    localparam int SINK_W     = 20;
    localparam int PROD_W     = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] PROFILE_KIND_FIXED = 2'b00;

    localparam logic [CUR_W-1:0]  CUR_STEP_MA  = 14'd10;
    localparam logic [VOLT_W-1:0] VOLT_STEP_MV = 16'd50;
    localparam logic [PROD_W-1:0] MW_DIVISOR   = 30'd1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CURRENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLTAGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLTAGE = 2'd3;

    localparam logic              MODE_MAX_POWER   = 1'b1;
    localparam logic [CUR_W-1:0]  RST_MIN_CURRENT  = 14'd500;
    localparam logic [VOLT_W-1:0] RST_MIN_VOLTAGE  = 16'd5000;
    localparam logic [VOLT_W-1:0] RST_MAX_VOLTAGE  = 16'd20000;

    typedef struct packed {
        logic              select_mode;
        logic [CUR_W-1:0]  floor_ma;
        logic [VOLT_W-1:0] floor_mv;
        logic [VOLT_W-1:0] ceiling_mv;
    } t_cfg;

    // one decoded profile, ready for the compare stage
    typedef struct packed {
        logic [UNITS_W-1:0] cur_units;
        logic [UNITS_W-1:0] volt_units;
        logic [CUR_W-1:0]   cur_ma;
        logic [VOLT_W-1:0]  volt_mv;
        logic [PWR_W-1:0]   pwr_mw;
        logic [PROD_W-1:0]  floor_prod;
        logic               ok_max;
        logic               ok_opt;
        logic               max_mode;
        logic               last;
    } t_item;

endpackage

### rtl/pdss_decode.sv
// ----------------------------------------------------------------------------
// pdss_decode
// Splits a source profile into current, voltage and power and applies the
// voltage and current limits of both modes.
// ----------------------------------------------------------------------------
module pdss_decode (
    input  logic [pdss_pkg::PDO_W-1:0] i_source_profile,
    input  logic                       i_last_profile,
    input  pdss_pkg::t_cfg             i_cfg,
    output pdss_pkg::t_item            o_item
);
    import pdss_pkg::*;

    logic [1:0]         prof_kind;
    logic [UNITS_W-1:0] cu;
    logic [UNITS_W-1:0] vu;
    logic [CUR_W-1:0]   cur_ma;
    logic [VOLT_W-1:0]  volt_mv;
    logic [SINK_W-1:0]  units_prod;
    logic               ok_max;

    assign prof_kind = i_source_profile[31:30];
    assign cu        = i_source_profile[9:0];
    assign vu        = i_source_profile[19:10];
    assign cur_ma    = {{(CUR_W-UNITS_W){1'b0}}, cu} * CUR_STEP_MA;
    assign volt_mv   = {{(VOLT_W-UNITS_W){1'b0}}, vu} * VOLT_STEP_MV;

    // mA * mV / 1000 = (10 cu)(50 vu)/1000 = cu*vu/2
    assign units_prod = {{(SINK_W-UNITS_W){1'b0}}, cu} * {{(SINK_W-UNITS_W){1'b0}}, vu};

    assign ok_max = (prof_kind == PROFILE_KIND_FIXED) && (volt_mv <= i_cfg.ceiling_mv);

    always_comb begin
        o_item.cur_units  = cu;
        o_item.volt_units = vu;
        o_item.cur_ma     = cur_ma;
        o_item.volt_mv    = volt_mv;
        o_item.pwr_mw     = units_prod[SINK_W-1:1];
        // floor product in mA*mV; the starting power is this over 1000
        o_item.floor_prod = {{(PROD_W-CUR_W){1'b0}}, i_cfg.floor_ma}
                          * {{(PROD_W-VOLT_W){1'b0}}, i_cfg.floor_mv};
        o_item.ok_max     = ok_max;
        o_item.ok_opt     = ok_max && (cur_ma >= i_cfg.floor_ma)
                                   && (volt_mv >= i_cfg.floor_mv);
        o_item.max_mode   = i_cfg.select_mode;
        o_item.last       = i_last_profile;
    end

endmodule

### rtl/pd_source_profile_selector.sv
// ----------------------------------------------------------------------------
// pd_source_profile_selector
// Picks the sink profile from the source profiles of one capabilities message.
// Profiles are taken one per clock, each with a last flag; a result enters the
// output register when the last profile leaves the decode register, and waits
// there while the next message's profiles keep flowing in. The decode
// register feeds one compare stage that holds the running best, so throughput
// is one profile per cycle, limited only by a full output register when a last
// profile waits.
// The starting best of optimal mode is kept as the raw floor product and
// compared against power times 1000, which needs no divider.
// ----------------------------------------------------------------------------
module pd_source_profile_selector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pdss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pdss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [pdss_pkg::PDO_W-1:0]      i_source_profile,
    input  logic                            i_last_profile,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [pdss_pkg::SINK_W-1:0]     o_sink_profile,
    output logic [pdss_pkg::VOLT_W-1:0]     o_chosen_voltage_mv,
    output logic [pdss_pkg::CUR_W-1:0]      o_chosen_current_ma,
    output logic [pdss_pkg::PWR_W-1:0]      o_chosen_power_mw
);
    import pdss_pkg::*;

    t_cfg  r_cfg;
    t_item dec_item;
    t_item r_a;
    logic  r_a_valid;

    // compare stage state
    logic               r_in_msg;
    logic               r_found;
    logic [PROD_W-1:0]  r_start_prod;
    logic [UNITS_W-1:0] r_best_cu;
    logic [UNITS_W-1:0] r_best_vu;
    logic [CUR_W-1:0]   r_best_cur;
    logic [VOLT_W-1:0]  r_best_volt;
    logic [PWR_W-1:0]   r_best_pwr;

    logic               r_out_valid;
    logic               r_out_found;
    logic [SINK_W-1:0]  r_out_sink;
    logic [VOLT_W-1:0]  r_out_volt;
    logic [CUR_W-1:0]   r_out_cur;
    logic [PWR_W-1:0]   r_out_pwr;

    logic               out_free;
    logic               a_go;
    logic               first;
    logic               found_eff;
    logic [PROD_W-1:0]  start_prod;
    logic [PROD_W-1:0]  pwr_ext;
    logic [PROD_W-1:0]  pwr_x1000;
    logic               beats_geq;
    logic               beats_gt;
    logic               take;
    logic               n_found;
    logic [UNITS_W-1:0] n_best_cu;
    logic [UNITS_W-1:0] n_best_vu;
    logic [CUR_W-1:0]   n_best_cur;
    logic [VOLT_W-1:0]  n_best_volt;
    logic [PWR_W-1:0]   n_best_pwr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.select_mode <= MODE_MAX_POWER;
            r_cfg.floor_ma    <= RST_MIN_CURRENT;
            r_cfg.floor_mv    <= RST_MIN_VOLTAGE;
            r_cfg.ceiling_mv  <= RST_MAX_VOLTAGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SELECT_MODE: r_cfg.select_mode <= i_cfg_data[0];
                REG_MIN_CURRENT: r_cfg.floor_ma    <= i_cfg_data[CUR_W-1:0];
                REG_MIN_VOLTAGE: r_cfg.floor_mv    <= i_cfg_data;
                REG_MAX_VOLTAGE: r_cfg.ceiling_mv  <= i_cfg_data;
            endcase
        end
    end

    pdss_decode u_decode (
        .i_source_profile (i_source_profile),
        .i_last_profile   (i_last_profile),
        .i_cfg            (r_cfg),
        .o_item           (dec_item)
    );

    // a last profile advances only when the output register can take its result
    assign out_free   = !r_out_valid || i_out_ready;
    assign a_go       = r_a_valid && (!r_a.last || out_free);
    assign o_in_ready = !r_a_valid || a_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a <= dec_item;
        end
    end

    // compare against the running best
    assign first      = !r_in_msg;
    assign found_eff  = first ? 1'b0 : r_found;
    assign start_prod = first ? (r_a.max_mode ? '0 : r_a.floor_prod) : r_start_prod;
    assign pwr_ext    = {{(PROD_W-PWR_W){1'b0}}, r_a.pwr_mw};
    assign pwr_x1000  = (pwr_ext << 10) - (pwr_ext << 4) - (pwr_ext << 3);

    // pwr >= floor(P/1000) iff P < 1000*pwr + 1000; pwr > floor(P/1000) iff P < 1000*pwr
    always_comb begin
        if (found_eff) begin
            beats_geq = r_a.pwr_mw >= r_best_pwr;
            beats_gt  = r_a.pwr_mw >  r_best_pwr;
        end else begin
            beats_geq = start_prod < (pwr_x1000 + MW_DIVISOR);
            beats_gt  = start_prod < pwr_x1000;
        end
    end

    assign take = r_a.max_mode ? (r_a.ok_max && beats_geq) : (r_a.ok_opt && beats_gt);

    always_comb begin
        n_found     = found_eff || take;
        n_best_cu   = r_best_cu;
        n_best_vu   = r_best_vu;
        n_best_cur  = r_best_cur;
        n_best_volt = r_best_volt;
        n_best_pwr  = r_best_pwr;
        if (take) begin
            n_best_cu   = r_a.cur_units;
            n_best_vu   = r_a.volt_units;
            n_best_cur  = r_a.cur_ma;
            n_best_volt = r_a.volt_mv;
            n_best_pwr  = r_a.pwr_mw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_found  <= 1'b0;
        end else if (a_go) begin
            r_in_msg <= !r_a.last;
            r_found  <= n_found && !r_a.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_start_prod <= start_prod;
            r_best_cu    <= n_best_cu;
            r_best_vu    <= n_best_vu;
            r_best_cur   <= n_best_cur;
            r_best_volt  <= n_best_volt;
            r_best_pwr   <= n_best_pwr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_go && r_a.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go && r_a.last) begin
            r_out_found <= n_found;
            if (n_found) begin
                r_out_sink <= {n_best_vu, n_best_cu};
                r_out_volt <= n_best_volt;
                r_out_cur  <= n_best_cur;
                r_out_pwr  <= n_best_pwr;
            end else begin
                r_out_sink <= '0;
                r_out_volt <= '0;
                r_out_cur  <= '0;
                r_out_pwr  <= '0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_found             = r_out_found;
    assign o_sink_profile      = r_out_sink;
    assign o_chosen_voltage_mv = r_out_volt;
    assign o_chosen_current_ma = r_out_cur;
    assign o_chosen_power_mw   = r_out_pwr;

endmodule

### rtl/pdss_checker.sv
// ----------------------------------------------------------------------------
// pdss_checker
// Port-level checks for the source profile selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "pd_source_profile_selector_macros.svh"

module pdss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_found,
    input logic [pdss_pkg::SINK_W-1:0]     o_sink_profile,
    input logic [pdss_pkg::VOLT_W-1:0]     o_chosen_voltage_mv,
    input logic [pdss_pkg::CUR_W-1:0]      o_chosen_current_ma,
    input logic [pdss_pkg::PWR_W-1:0]      o_chosen_power_mw
);
    import pdss_pkg::*;

    `PDSS_ASSERT_NXT_RST(a_rst_clears_out, i_clk, !i_rst_n, !o_out_valid,
        "result valid after reset")

    `PDSS_ASSERT_IMP(a_ready_when_out_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready,
        "input stalled with an empty result register")

    `PDSS_ASSERT_IMP(a_none_found_zero, i_clk, i_rst_n, o_out_valid && !o_found,
        (o_sink_profile == '0) && (o_chosen_voltage_mv == '0)
            && (o_chosen_current_ma == '0) && (o_chosen_power_mw == '0),
        "fields not zero when nothing was found")

    `PDSS_ASSERT_IMP(a_word_matches_fields, i_clk, i_rst_n, o_out_valid && o_found,
        (o_chosen_current_ma == ({4'b0, o_sink_profile[9:0]} * CUR_STEP_MA))
            && (o_chosen_voltage_mv == ({6'b0, o_sink_profile[19:10]} * VOLT_STEP_MV)),
        "sink profile word disagrees with chosen current or voltage")

    `PDSS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_found) && $stable(o_sink_profile)
            && $stable(o_chosen_power_mw),
        "stalled result changed")

endmodule

bind pd_source_profile_selector pdss_checker u_pdss_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_found             (o_found),
    .o_sink_profile      (o_sink_profile),
    .o_chosen_voltage_mv (o_chosen_voltage_mv),
    .o_chosen_current_ma (o_chosen_current_ma),
    .o_chosen_power_mw   (o_chosen_power_mw)
);
